### design/mmrc_pkg.sv
// Shared types, codes and helpers for the memory map range checker.
package mmrc_pkg;

  // Item modes.
  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  // Result status codes.
  localparam logic [1:0] STATUS_DONE     = 2'd0;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_START = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_END   = 1'd1;

  // Longest region that is still stored.
  localparam logic [63:0] LEN_LIMIT = 64'h0000_0001_0000_0000;

  // Type code of usable memory.
  localparam logic [31:0] USABLE_TYPE = 32'd1;

  // One stored region.
  typedef struct packed {
    logic        usable;
    logic [63:0] end_addr;
    logic [63:0] start_addr;
  } region_t;

  localparam int unsigned ENTRY_W = $bits(region_t);

  // Answer from the scan engine.
  typedef struct packed {
    logic done;
    logic usable;
  } scan_rsp_t;

  // Unsigned overlap test of [s1,e1) against [s2,e2), with no special
  // treatment of empty or wrapped ranges.
  function automatic logic ranges_touch(input logic [63:0] s1, input logic [63:0] e1,
                                        input logic [63:0] s2, input logic [63:0] e2);
    logic res;
    if (s1 < s2) begin
      res = (e1 > s2);
    end else begin
      res = (s1 < e2);
    end
    return res;
  endfunction

endpackage

### design/mmrc_if.sv
// Handshake interfaces for the item, result and configuration channels.
interface mmrc_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [63:0] range_start;
  logic [63:0] range_end;
  logic [63:0] entry_length;
  logic [31:0] entry_type;

  modport source (output valid, mode, range_start, range_end, entry_length, entry_type,
                  input ready);
  modport sink (input valid, mode, range_start, range_end, entry_length, entry_type,
                output ready);
endinterface

interface mmrc_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       map_usable;
  logic       outside_kernel;
  logic       range_usable;
  logic [7:0] entry_count;

  modport source (output valid, status, map_usable, outside_kernel, range_usable,
                  entry_count, input ready);
  modport sink (input valid, status, map_usable, outside_kernel, range_usable,
                entry_count, output ready);
endinterface

interface mmrc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mmrc_pkg::CFG_IDX_W-1:0] index;
  logic [63:0]                   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### design/mmrc_ram.sv
// Single-port-write, single-port-read region table with registered read data.
module mmrc_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int DW    = 129
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/mmrc_scan.sv
// Ordered scan engine: reads one region a cycle and decides at the first match.
module mmrc_scan #(
  parameter int CNT_W = 8,
  parameter int IDX_W = 7
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [CNT_W-1:0]         count,
  input  logic [63:0]              q_start,
  input  logic [63:0]              q_end,
  output logic                     rd_en,
  output logic [IDX_W-1:0]         rd_addr,
  input  logic [mmrc_pkg::ENTRY_W-1:0] rd_data,
  output mmrc_pkg::scan_rsp_t      rsp
);

  logic             busy;
  logic [CNT_W-1:0] issue_idx;
  logic             data_valid;
  logic             data_last;
  mmrc_pkg::region_t entry;
  logic             hit_bad;
  logic             hit_good;

  assign entry   = mmrc_pkg::region_t'(rd_data);
  assign rd_en   = busy && (issue_idx < count);
  assign rd_addr = issue_idx[IDX_W-1:0];

  // A non-usable overlapping region ends the scan first, as it is tested first.
  assign hit_bad  = !entry.usable &&
                    mmrc_pkg::ranges_touch(q_start, q_end, entry.start_addr, entry.end_addr);
  assign hit_good = entry.usable && (q_start >= entry.start_addr) &&
                    (q_end <= entry.end_addr);

  always_comb begin
    rsp.done   = data_valid && (hit_bad || hit_good || data_last);
    rsp.usable = !hit_bad && hit_good;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      data_valid <= 1'b0;
      data_last  <= 1'b0;
      issue_idx  <= '0;
    end else if (start) begin
      busy       <= 1'b1;
      data_valid <= 1'b0;
      issue_idx  <= '0;
    end else if (rsp.done) begin
      busy       <= 1'b0;
      data_valid <= 1'b0;
    end else begin
      data_valid <= rd_en;
      data_last  <= (issue_idx + CNT_W'(1)) == count;
      if (rd_en) begin
        issue_idx <= issue_idx + CNT_W'(1);
      end
    end
  end

endmodule

### design/memory_map_range_checker.sv
// Top level of the memory map range checker: control, table count and result register.
// An accepted item word is registered, carried out in the execute state and, for a query
// with regions stored, settled by a scan of the table in stored order; its result word
// is loaded into the result register once that register is free. One item is in work at
// a time: no new word is taken until the last result word is loaded. Reset (synchronous)
// empties the table and clears the kernel registers.
module memory_map_range_checker #(
  parameter int MAP_ENTRIES = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  mmrc_item_if.sink            item,
  mmrc_result_if.source        result,
  mmrc_cfg_if.sink             cfg
);

  localparam int CNT_W = $clog2(MAP_ENTRIES + 1);
  localparam int IDX_W = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state;

  // The accepted word, held while it is worked on.
  logic [1:0]  it_mode;
  logic [63:0] it_start;
  logic [63:0] it_end;
  logic [63:0] it_len;
  logic        it_usable;

  logic [63:0]      kernel_start;
  logic [63:0]      kernel_end;
  logic [CNT_W-1:0] count;

  // Per-item answers, collected before the result register is loaded.
  logic [1:0] res_status;
  logic       res_map;
  logic       res_kernel;

  // Result register.
  logic       out_valid;
  logic [1:0] out_status;
  logic       out_map;
  logic       out_kernel;
  logic [7:0] out_count;

  logic item_acc;
  logic slot_free;
  logic too_long;
  logic full;
  logic scan_start;

  logic                         wr_en;
  logic [mmrc_pkg::ENTRY_W-1:0] wr_data;
  mmrc_pkg::region_t            new_region;
  logic                         rd_en;
  logic [IDX_W-1:0]             rd_addr;
  logic [mmrc_pkg::ENTRY_W-1:0] rd_data;
  mmrc_pkg::scan_rsp_t          scan_rsp;

  assign item.ready = (state == S_IDLE);
  assign item_acc   = item.valid && item.ready;
  assign cfg.ready  = 1'b1;

  // The result register frees up in the same cycle as its word is taken.
  assign slot_free = !out_valid || result.ready;

  assign too_long   = it_len > mmrc_pkg::LEN_LIMIT;
  assign full       = (count == CNT_W'(MAP_ENTRIES));
  assign scan_start = (state == S_EXEC) && (it_mode == mmrc_pkg::MODE_QUERY) &&
                      (count != '0);

  // A load is appended at the current count. Loads and queries never overlap,
  // so a scan never reads an entry that is still being written.
  always_comb begin
    new_region.usable     = it_usable;
    new_region.start_addr = it_start;
    new_region.end_addr   = it_start + it_len;
  end
  assign wr_data = new_region;
  assign wr_en   = (state == S_EXEC) && (it_mode == mmrc_pkg::MODE_LOAD) && !too_long && !full;

  mmrc_ram #(
    .DEPTH (MAP_ENTRIES),
    .AW    (IDX_W),
    .DW    (mmrc_pkg::ENTRY_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mmrc_scan #(
    .CNT_W (CNT_W),
    .IDX_W (IDX_W)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .start   (scan_start),
    .count   (count),
    .q_start (it_start),
    .q_end   (it_end),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .rsp     (scan_rsp)
  );

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_start <= '0;
      kernel_end   <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        mmrc_pkg::REG_KERNEL_START: kernel_start <= cfg.data;
        mmrc_pkg::REG_KERNEL_END:   kernel_end   <= cfg.data;
        default: ;
      endcase
    end
  end

  // Control sequence, table count and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // Loading a new word takes precedence over emptying the register, since both can
      // fall on the edge at which the old word is taken.
      if (state == S_DONE && slot_free) begin
        out_valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_acc) begin
            it_mode   <= item.mode;
            it_start  <= item.range_start;
            it_end    <= item.range_end;
            it_len    <= item.entry_length;
            it_usable <= (item.entry_type == mmrc_pkg::USABLE_TYPE);
            state     <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_map <= 1'b0;
          // The length check takes precedence over the full check.
          if (it_mode == mmrc_pkg::MODE_LOAD && too_long) begin
            res_status <= mmrc_pkg::STATUS_TOO_LONG;
          end else if (it_mode == mmrc_pkg::MODE_LOAD && full) begin
            res_status <= mmrc_pkg::STATUS_FULL;
          end else begin
            res_status <= mmrc_pkg::STATUS_DONE;
          end
          if (it_mode == mmrc_pkg::MODE_QUERY) begin
            res_kernel <= !mmrc_pkg::ranges_touch(it_start, it_end,
                                                  kernel_start, kernel_end);
          end else begin
            res_kernel <= 1'b0;
          end
          // An empty table answers at once: nothing can make the range usable.
          if (scan_start) begin
            state <= S_SCAN;
          end else begin
            state <= S_DONE;
          end
          case (it_mode)
            mmrc_pkg::MODE_CLEAR: begin
              count <= '0;
            end
            mmrc_pkg::MODE_LOAD: begin
              if (!too_long && !full) begin
                count <= count + CNT_W'(1);
              end
            end
            default: ;
          endcase
        end
        S_SCAN: begin
          if (scan_rsp.done) begin
            res_map <= scan_rsp.usable;
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            out_status <= res_status;
            out_map    <= res_map;
            out_kernel <= res_kernel;
            out_count  <= 8'(count);
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid          = out_valid;
  assign result.status         = out_status;
  assign result.map_usable     = out_map;
  assign result.outside_kernel = out_kernel;
  assign result.range_usable   = out_map && out_kernel;
  assign result.entry_count    = out_count;

  // The table never holds more regions than it has room for.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAP_ENTRIES))
    else $error("region count beyond table depth");

  // The scan engine only answers while the control waits for it.
  a_scan_owned: assert property (@(posedge clk) disable iff (rst)
    scan_rsp.done |-> state == S_SCAN)
    else $error("scan answer outside a query");

  // A finished item always reaches the result register once there is room.
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && slot_free) |=> (result.valid && state == S_IDLE))
    else $error("finished item not delivered");

  // The table is written only while a load is carried out.
  a_write_load: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_EXEC && it_mode == mmrc_pkg::MODE_LOAD))
    else $error("table written outside a load");

endmodule

### verif/memory_map_range_checker_test.sv
// Self-checking testbench for the memory map range checker, with its own table predictor.
`timescale 1ns / 1ps

module memory_map_range_checker_test;

  // The table depth that the block is built with, and the stopping points of the run.
  localparam int unsigned TABLE_DEPTH = 128;
  localparam int unsigned WORD_TARGET = 450;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SETTLE_CYCLES = 140;

  // Mode 3 is not used by the block; such words must still give a quiet result.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Region type codes used as stimulus besides usable memory.
  localparam logic [31:0] TYPE_NONE = 32'd0;
  localparam logic [31:0] TYPE_RESERVED = 32'd2;
  localparam logic [31:0] TYPE_RECLAIM = 32'd3;

  localparam logic [63:0] ALL_ONES = '1;

  typedef struct {
    logic [1:0]  mode;
    logic [63:0] base;
    logic [63:0] limit;
    logic [63:0] length;
    logic [31:0] kind;
  } map_word_t;

  typedef struct {
    logic [1:0] status;
    logic       map_ok;
    logic       clear_of_kernel;
    logic       range_ok;
    logic [7:0] count;
  } answer_t;

  // How the result side holds off: always ready, coin toss, fixed pattern or long runs.
  typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_PATTERN, STALL_RUNS} stall_style_t;

  logic clk = 1'b0;
  logic rst;

  mmrc_item_if   item_bus();
  mmrc_result_if answer_bus();
  mmrc_cfg_if    cfg_bus();

  memory_map_range_checker uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (answer_bus),
    .cfg    (cfg_bus)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state: our own copy of the region table and of the kernel registers.
  logic [63:0] table_lo [TABLE_DEPTH];
  logic [63:0] table_hi [TABLE_DEPTH];
  logic        table_usable [TABLE_DEPTH];
  int unsigned table_count;
  logic [63:0] kernel_lo;
  logic [63:0] kernel_hi;

  // Words waiting to be sent, and the answers that accepted words must produce.
  map_word_t   pending_words[$];
  answer_t     answers[$];
  int unsigned issued_total;
  int unsigned accepted_total;
  int unsigned stimulus_words;
  int unsigned mismatch_count;
  int unsigned cycles;

  // The generator's view of the regions it has loaded since the last clear, used to aim
  // queries at region edges rather than at empty address space.
  logic [63:0] loaded_lo[$];
  logic [63:0] loaded_hi[$];

  // Unsigned overlap of [s1,e1) with [s2,e2). Empty and wrapped ranges get no special
  // treatment, exactly as the block's own comparison behaves.
  function automatic logic spans_overlap(input logic [63:0] s1, input logic [63:0] e1,
                                         input logic [63:0] s2, input logic [63:0] e2);
    if (s1 < s2) begin
      return e1 > s2;
    end
    return s1 < e2;
  endfunction

  // Applies one accepted word to the table copy and works out the result word it gives.
  function automatic answer_t predict_answer(input map_word_t w);
    answer_t     a;
    logic        decided;
    int unsigned i;
    a = '{mmrc_pkg::STATUS_DONE, 1'b0, 1'b0, 1'b0, 8'd0};
    decided = 1'b0;
    case (w.mode)
      mmrc_pkg::MODE_CLEAR: begin
        table_count = 0;
      end
      mmrc_pkg::MODE_LOAD: begin
        // The length check comes first, so an overlong region on a full table is
        // reported as too long rather than as refused.
        if (w.length > mmrc_pkg::LEN_LIMIT) begin
          a.status = mmrc_pkg::STATUS_TOO_LONG;
        end else if (table_count >= TABLE_DEPTH) begin
          a.status = mmrc_pkg::STATUS_FULL;
        end else begin
          table_lo[table_count] = w.base;
          table_hi[table_count] = w.base + w.length;
          table_usable[table_count] = (w.kind == mmrc_pkg::USABLE_TYPE);
          table_count++;
        end
      end
      mmrc_pkg::MODE_QUERY: begin
        // Stored order decides: the first non-usable region that touches the range, or the
        // first usable region that holds all of it, settles the answer.
        for (i = 0; i < table_count && !decided; i++) begin
          if (!table_usable[i] && spans_overlap(w.base, w.limit, table_lo[i], table_hi[i])) begin
            decided = 1'b1;
          end else if (table_usable[i] && w.base >= table_lo[i] && w.limit <= table_hi[i]) begin
            decided = 1'b1;
            a.map_ok = 1'b1;
          end
        end
        a.clear_of_kernel = !spans_overlap(w.base, w.limit, kernel_lo, kernel_hi);
        a.range_ok = a.map_ok & a.clear_of_kernel;
      end
      default: begin
      end
    endcase
    a.count = table_count[7:0];
    return a;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Puts one word on the send queue and keeps the generator's region list in step.
  function automatic void queue_word(input logic [1:0] mode, input logic [63:0] base,
                                     input logic [63:0] limit, input logic [63:0] length,
                                     input logic [31:0] kind);
    map_word_t w;
    w = '{mode, base, limit, length, kind};
    pending_words.push_back(w);
    issued_total++;
    if (mode != MODE_UNUSED) begin
      stimulus_words++;
    end
    if (mode == mmrc_pkg::MODE_CLEAR) begin
      loaded_lo.delete();
      loaded_hi.delete();
    end else if (mode == mmrc_pkg::MODE_LOAD && length <= mmrc_pkg::LEN_LIMIT) begin
      loaded_lo.push_back(base);
      loaded_hi.push_back(base + length);
    end
  endfunction

  // Mostly usable memory, with reserved and odd types mixed in.
  function automatic logic [31:0] pick_kind();
    case ($urandom_range(0, 9))
      6: return TYPE_RESERVED;
      7: return TYPE_NONE;
      8: return TYPE_RECLAIM;
      9: return $urandom;
      default: return mmrc_pkg::USABLE_TYPE;
    endcase
  endfunction

  // Mostly short regions so that they overlap within a window; now and then the length
  // sits on or just past the limit, or is wildly too long.
  function automatic logic [63:0] pick_length();
    case ($urandom_range(0, 15))
      0: return 64'd0;
      1: return mmrc_pkg::LEN_LIMIT;
      2: return mmrc_pkg::LEN_LIMIT + 64'd1;
      3: return rand64() | (64'd1 << 63);
      4: return {32'd0, $urandom};
      default: return 64'($urandom_range(1, 2048));
    endcase
  endfunction

  // Loads one region somewhere in the window. The range end is ignored by a load, so
  // it carries random bits.
  function automatic void load_region(input logic [63:0] window, input logic [63:0] length);
    queue_word(mmrc_pkg::MODE_LOAD, window + 64'($urandom_range(0, 8191)), rand64(), length,
               pick_kind());
  endfunction

  // Queries aimed at a loaded region: whole, inside, across either edge, reversed or
  // empty; otherwise somewhere in the window or anywhere at all.
  function automatic void queue_query(input logic [63:0] window);
    logic [63:0] lo, hi, s, e;
    int unsigned j;
    lo = window;
    hi = window + 64'd4096;
    if (loaded_lo.size() != 0) begin
      j = $urandom_range(0, loaded_lo.size() - 1);
      lo = loaded_lo[j];
      hi = loaded_hi[j];
    end
    case ($urandom_range(0, 8))
      0: begin
        s = lo;
        e = hi;
      end
      1, 2: begin
        s = lo + 64'($urandom_range(0, 64));
        e = s + 64'($urandom_range(1, 64));
      end
      3: begin
        s = lo - 64'($urandom_range(1, 64));
        e = lo + 64'($urandom_range(1, 64));
      end
      4: begin
        s = hi - 64'($urandom_range(1, 64));
        e = hi + 64'($urandom_range(0, 64));
      end
      5: begin
        s = window + 64'($urandom_range(0, 10000));
        e = s + 64'($urandom_range(0, 3000));
      end
      6: begin
        s = hi;
        e = lo;
      end
      7: begin
        s = lo + 64'($urandom_range(0, 32));
        e = s;
      end
      default: begin
        s = rand64();
        e = rand64();
      end
    endcase
    queue_word(mmrc_pkg::MODE_QUERY, s, e, rand64(), $urandom);
  endfunction

  // One register write; the valid is left high so that a following write runs on
  // without a gap, and the caller lowers it at the end.
  task automatic write_register(input logic [mmrc_pkg::CFG_IDX_W-1:0] idx,
                                input logic [63:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= value;
    @(posedge clk);
    while (!cfg_bus.ready) begin
      @(posedge clk);
    end
    case (idx)
      mmrc_pkg::REG_KERNEL_START: kernel_lo = value;
      mmrc_pkg::REG_KERNEL_END: kernel_hi = value;
      default: begin
      end
    endcase
  endtask

  task automatic set_kernel(input logic [63:0] lo, input logic [63:0] hi);
    @(posedge clk);
    write_register(mmrc_pkg::REG_KERNEL_START, lo);
    write_register(mmrc_pkg::REG_KERNEL_END, hi);
    cfg_bus.valid <= 1'b0;
  endtask

  // Waits until every queued word has been taken and every result word has come back.
  task automatic wait_drain();
    while (accepted_total != issued_total || answers.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic compare_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  // Sender: words go out in bursts of random length, with gaps between the bursts. Some
  // gaps are long enough to cover a whole table scan, so idle input lines up with every
  // stage of the block's work. A word is predicted at the edge at which it is taken.
  map_word_t   live_word;
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk) begin
    if (rst) begin
      item_bus.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (!item_bus.valid || item_bus.ready) begin
      if (item_bus.valid) begin
        answers.push_back(predict_answer(live_word));
        accepted_total++;
      end
      if (gap_left != 0) begin
        gap_left--;
        item_bus.valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        live_word = pending_words.pop_front();
        item_bus.valid <= 1'b1;
        item_bus.mode <= live_word.mode;
        item_bus.range_start <= live_word.base;
        item_bus.range_end <= live_word.limit;
        item_bus.entry_length <= live_word.length;
        item_bus.entry_type <= live_word.kind;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          if ($urandom_range(0, 2) == 0) begin
            gap_left = 0;
          end else if ($urandom_range(0, 3) == 0) begin
            gap_left = $urandom_range(1, 150);
          end else begin
            gap_left = $urandom_range(1, 12);
          end
        end else begin
          burst_left--;
        end
      end else begin
        item_bus.valid <= 1'b0;
      end
    end
  end

  // Receiver: checks each result word against the oldest expected answer, and holds off
  // in one of several styles, picked anew at random.
  stall_style_t stall_style;
  int unsigned  style_left;
  int unsigned  hold_left;
  logic         hold_take;

  always @(posedge clk) begin
    answer_t want;
    logic    take;
    if (rst) begin
      answer_bus.ready <= 1'b0;
      stall_style = STALL_NONE;
      style_left = 0;
      hold_left = 0;
      hold_take = 1'b0;
    end else begin
      if (answer_bus.valid && answer_bus.ready) begin
        if (answers.size() == 0) begin
          $display("%0t: result word arrived with no answer expected", $time);
          mismatch_count++;
        end else begin
          want = answers.pop_front();
          compare_field("status", 64'(want.status), 64'(answer_bus.status));
          compare_field("map_usable", 64'(want.map_ok), 64'(answer_bus.map_usable));
          compare_field("outside_kernel", 64'(want.clear_of_kernel),
                        64'(answer_bus.outside_kernel));
          compare_field("range_usable", 64'(want.range_ok), 64'(answer_bus.range_usable));
          compare_field("entry_count", 64'(want.count), 64'(answer_bus.entry_count));
        end
      end
      if (style_left == 0) begin
        stall_style = stall_style_t'($urandom_range(0, 3));
        style_left = $urandom_range(50, 400);
      end else begin
        style_left--;
      end
      case (stall_style)
        STALL_NONE: take = 1'b1;
        STALL_COIN: take = 1'($urandom_range(0, 1));
        STALL_PATTERN: take = (style_left % 5) != 0;
        default: begin
          if (hold_left == 0) begin
            hold_take = !hold_take;
            hold_left = $urandom_range(1, 20);
          end else begin
            hold_left--;
          end
          take = hold_take;
        end
      endcase
      answer_bus.ready <= take;
    end
  end

  // Watchdog: a hung block ends the run as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("memory_map_range_checker_test failed");
      $finish;
    end
  end

  // Stimulus and the end of the run.
  initial begin
    logic [63:0] window;
    logic [63:0] k_lo;
    logic [63:0] k_hi;
    int unsigned phase;
    int unsigned n;

    // Every input is known from the first instant, before reset takes hold.
    rst = 1'b1;
    item_bus.valid = 1'b0;
    item_bus.mode = mmrc_pkg::MODE_CLEAR;
    item_bus.range_start = '0;
    item_bus.range_end = '0;
    item_bus.entry_length = '0;
    item_bus.entry_type = '0;
    answer_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = mmrc_pkg::REG_KERNEL_START;
    cfg_bus.data = '0;
    table_count = 0;
    kernel_lo = '0;
    kernel_hi = '0;
    issued_total = 0;
    accepted_total = 0;
    stimulus_words = 0;
    mismatch_count = 0;
    cycles = 0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part: a small map with a reserved hole inside usable memory, the length
    // limit on both sides, a region that wraps past the top of the address space, odd
    // types, queries that straddle the hole and the kernel, the unused mode, and a clear.
    set_kernel(64'h1000, 64'h2000);
    queue_word(mmrc_pkg::MODE_QUERY, 64'h0, 64'h10, '0, '0);
    queue_word(mmrc_pkg::MODE_LOAD, 64'h2_0000, ALL_ONES, 64'h100, TYPE_RESERVED);
    queue_word(mmrc_pkg::MODE_LOAD, 64'h1_0000, '0, 64'h2_0000, mmrc_pkg::USABLE_TYPE);
    queue_word(mmrc_pkg::MODE_QUERY, 64'h1_0000, 64'h1_0100, '0, '0);
    queue_word(mmrc_pkg::MODE_QUERY, 64'h1_FF00, 64'h2_0080, '0, '0);
    queue_word(mmrc_pkg::MODE_QUERY, 64'h1_0000, 64'h3_0000, '0, '0);
    queue_word(mmrc_pkg::MODE_QUERY, 64'h2_0100, 64'h3_0000, ALL_ONES, ALL_ONES[31:0]);
    queue_word(mmrc_pkg::MODE_LOAD, 64'h1_0000_0000, '0, mmrc_pkg::LEN_LIMIT,
               mmrc_pkg::USABLE_TYPE);
    queue_word(mmrc_pkg::MODE_LOAD, 64'h8_0000_0000, '0, mmrc_pkg::LEN_LIMIT + 64'd1,
               mmrc_pkg::USABLE_TYPE);
    queue_word(mmrc_pkg::MODE_LOAD, 64'h0, '0, ALL_ONES, mmrc_pkg::USABLE_TYPE);
    queue_word(mmrc_pkg::MODE_LOAD, ALL_ONES - 64'hFF, '0, 64'h200, mmrc_pkg::USABLE_TYPE);
    queue_word(mmrc_pkg::MODE_QUERY, ALL_ONES - 64'hFF, ALL_ONES, '0, '0);
    queue_word(mmrc_pkg::MODE_QUERY, ALL_ONES - 64'hFF, 64'h80, '0, '0);
    queue_word(mmrc_pkg::MODE_LOAD, 64'h0, '0, 64'h0, TYPE_NONE);
    queue_word(mmrc_pkg::MODE_LOAD, 64'h4000, '0, 64'h1000, ALL_ONES[31:0]);
    queue_word(mmrc_pkg::MODE_QUERY, 64'h0, ALL_ONES, '0, '0);
    queue_word(mmrc_pkg::MODE_QUERY, 64'h1800, 64'h1900, '0, '0);
    queue_word(mmrc_pkg::MODE_QUERY, 64'h1_8000, 64'h1_8000, '0, '0);
    queue_word(mmrc_pkg::MODE_QUERY, 64'h1_0000_0000, 64'h1_8000_0000, '0, '0);
    queue_word(MODE_UNUSED, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES[31:0]);
    queue_word(mmrc_pkg::MODE_CLEAR, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES[31:0]);
    queue_word(mmrc_pkg::MODE_QUERY, 64'h1_0000, 64'h1_0100, '0, '0);
    wait_drain();

    // Random part: each phase moves to a fresh address window and kernel setting, then
    // sends a map load followed by a mix of loads and queries, with a little noise. One
    // phase fills the table to the brim and pushes past it.
    phase = 0;
    while (stimulus_words < WORD_TARGET) begin
      case ($urandom_range(0, 3))
        0: window = '0;
        1: window = ALL_ONES - 64'h1FFF;
        default: window = rand64() & ~64'hFFF;
      endcase
      case (phase % 6)
        0: begin
          k_lo = '0;
          k_hi = ALL_ONES;
        end
        1: begin
          k_lo = ALL_ONES;
          k_hi = '0;
        end
        2: begin
          k_lo = '0;
          k_hi = '0;
        end
        3: begin
          k_lo = ALL_ONES;
          k_hi = ALL_ONES;
        end
        4: begin
          k_lo = window + 64'($urandom_range(0, 8191));
          k_hi = k_lo + 64'($urandom_range(0, 4096));
        end
        default: begin
          k_lo = rand64();
          k_hi = rand64();
        end
      endcase
      set_kernel(k_lo, k_hi);

      if (phase == 3) begin
        queue_word(mmrc_pkg::MODE_CLEAR, rand64(), rand64(), rand64(), $urandom);
        repeat (TABLE_DEPTH) load_region(window, 64'($urandom_range(0, 4096)));
        repeat (3) queue_query(window);
        // On a full table an overlong region is still reported as too long.
        load_region(window, rand64() | (64'd1 << 63));
        load_region(window, 64'($urandom_range(0, 4096)));
        load_region(window, mmrc_pkg::LEN_LIMIT);
        repeat (4) queue_query(window);
      end else begin
        if ($urandom_range(0, 3) != 0) begin
          queue_word(mmrc_pkg::MODE_CLEAR, rand64(), rand64(), rand64(), $urandom);
        end
        repeat ($urandom_range(1, 10)) load_region(window, pick_length());
        n = $urandom_range(6, 18);
        repeat (n) begin
          if ($urandom_range(0, 3) == 0) begin
            load_region(window, pick_length());
          end else begin
            queue_query(window);
          end
        end
        repeat ($urandom_range(0, 2)) begin
          queue_word(2'($urandom_range(0, 3)), rand64(), rand64(), rand64(), $urandom);
        end
      end
      wait_drain();
      phase++;
    end

    // Let any late stray result word show itself before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && answers.size() == 0) begin
      $display("memory_map_range_checker_test passed");
    end else begin
      $display("memory_map_range_checker_test failed");
    end
    $finish;
  end

endmodule

### files.f
design/mmrc_pkg.sv
design/mmrc_if.sv
design/mmrc_ram.sv
design/mmrc_scan.sv
design/memory_map_range_checker.sv
verif/memory_map_range_checker_test.sv
